// ===== design/drfd_pkg.sv =====
// shared types and constants for the display return frame dispatcher
// used by every module of the block; depends on nothing
`timescale 1ns / 1ps

package drfd_pkg;

  // table size default and fixed frame constants
  localparam int unsigned HANDLER_SLOTS_DEF = 16;
  localparam int unsigned HEAD_LEN          = 5;
  localparam logic [7:0]  ERR_LIMIT         = 8'h24;
  localparam logic [7:0]  TERM_BYTE         = 8'hFF;
  localparam logic [7:0]  PRESS_BYTE        = 8'h01;
  localparam logic [7:0]  RELEASE_BYTE      = 8'h00;
  localparam int unsigned MAX_MATCHES       = 16;

  // configuration register indexes
  localparam logic [1:0] CFG_TOUCH_CODE = 2'd0;
  localparam logic [1:0] CFG_PAGE_CODE  = 2'd1;
  localparam logic [1:0] CFG_NUM_CODE   = 2'd2;

  // request types on the input channel
  localparam logic REQ_BYTE     = 1'b0;
  localparam logic REQ_REGISTER = 1'b1;

  // result kinds
  localparam logic [1:0] KIND_ERROR = 2'd0;
  localparam logic [1:0] KIND_TOUCH = 2'd1;
  localparam logic [1:0] KIND_PAGE  = 2'd2;
  localparam logic [1:0] KIND_NUM   = 2'd3;

  // work handed from front to back
  typedef enum logic [2:0] {
    OP_REG   = 3'd0,
    OP_ERR   = 3'd1,
    OP_TOUCH = 3'd2,
    OP_PAGE  = 3'd3,
    OP_NUM   = 3'd4
  } op_t;

  // data: register -> {rel, page, id}; touch -> {id, page} in the low half;
  // error, page, numeric -> the value to report
  typedef struct packed {
    op_t         op;
    logic        want_rel;
    logic [31:0] data;
  } job_t;

endpackage

// ===== design/display_return_frame_dispatcher.sv =====
// top level of the display return frame dispatcher
// depends on drfd_pkg, drfd_front, drfd_queue, drfd_back
`timescale 1ns / 1ps

// Usage:
//   Input beats carry either a received link byte (req_type 0) or a touch
//   handler registration (req_type 1). A frame ends at the third 0xFF in a row
//   and is decoded into an error, touch matches, a page number or a number.
//   Result beats carry kind, value, slot and a last flag for the frame.
//   The cfg port writes the three frame codes; write only while idle.
// Timing:
//   One byte or registration is taken per cycle while the two-entry job
//   queue has room. Error, page and numeric results pass from the closing
//   byte through the job queue into the output register. A touch frame walks
//   the handler table one slot per cycle while no hit waits on a stalled
//   result register; the single table read port sets that pace.
// Reset and stall:
//   Reset clears the frame, the table fill count and the queue and restores
//   the default codes. A stalled result holds in the output register; the
//   back side stops at its next result and the queue fills until in_stall rises.

module display_return_frame_dispatcher import drfd_pkg::*; #(
  parameter int unsigned HANDLER_SLOTS = HANDLER_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_req_type,
  input  logic [7:0]  in_rx_byte,
  input  logic [7:0]  in_handler_id,
  input  logic [7:0]  in_handler_page,
  input  logic        in_on_release_flag,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_result_kind,
  output logic [31:0] out_result_value,
  output logic [3:0]  out_handler_slot,
  output logic        out_last_result
);

  job_t wr_job, rd_job;
  logic push, pop, q_full, q_empty;

  assign in_stall = q_full;

  // byte collection and classification
  drfd_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_req_type        (in_req_type),
    .in_rx_byte         (in_rx_byte),
    .in_handler_id      (in_handler_id),
    .in_handler_page    (in_handler_page),
    .in_on_release_flag (in_on_release_flag),
    .q_full             (q_full),
    .q_push             (push),
    .q_job              (wr_job)
  );

  // job queue
  drfd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_push  (push),
    .wr_job   (wr_job),
    .rd_pop   (pop),
    .wr_full  (q_full),
    .rd_empty (q_empty),
    .rd_job   (rd_job)
  );

  // table, slot walk and results
  drfd_back #(
    .HANDLER_SLOTS (HANDLER_SLOTS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_job            (rd_job),
    .q_pop            (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_kind  (out_result_kind),
    .out_result_value (out_result_value),
    .out_handler_slot (out_handler_slot),
    .out_last_result  (out_last_result)
  );

endmodule

// ===== design/drfd_front.sv =====
// front side: configuration registers, frame collection and frame classification
// depends on drfd_pkg; feeds jobs to drfd_queue
`timescale 1ns / 1ps

module drfd_front import drfd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata,
  input  logic       in_valid,
  input  logic       in_req_type,
  input  logic [7:0] in_rx_byte,
  input  logic [7:0] in_handler_id,
  input  logic [7:0] in_handler_page,
  input  logic       in_on_release_flag,
  input  logic       q_full,
  output logic       q_push,
  output job_t       q_job
);

  logic [7:0] touch_code_r, page_code_r, num_code_r;
  logic [7:0] head_r   [HEAD_LEN];
  logic [7:0] head_nxt [HEAD_LEN];
  logic [2:0] bytes_seen_r, bytes_seen_nxt;
  logic [1:0] ff_run_r, ff_run_nxt;
  logic       accept, byte_beat, frame_end, job_valid;
  logic [7:0] code;

  assign accept    = in_valid && !q_full;
  assign byte_beat = accept && (in_req_type == REQ_BYTE);
  assign frame_end = (ff_run_r == 2'd2) && (in_rx_byte == TERM_BYTE);

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      touch_code_r <= 8'd101;
      page_code_r  <= 8'd102;
      num_code_r   <= 8'd113;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TOUCH_CODE: touch_code_r <= cfg_wdata;
        CFG_PAGE_CODE:  page_code_r  <= cfg_wdata;
        CFG_NUM_CODE:   num_code_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // head bytes with the incoming byte placed
  always_comb begin
    for (int i = 0; i < HEAD_LEN; i++) head_nxt[i] = head_r[i];
    if (bytes_seen_r < 3'(HEAD_LEN)) head_nxt[bytes_seen_r] = in_rx_byte;
  end

  // frame state update
  always_comb begin
    bytes_seen_nxt = bytes_seen_r;
    ff_run_nxt     = ff_run_r;
    if (frame_end) begin
      bytes_seen_nxt = 3'd0;
      ff_run_nxt     = 2'd0;
    end else begin
      if (bytes_seen_r < 3'(HEAD_LEN)) bytes_seen_nxt = bytes_seen_r + 3'd1;
      ff_run_nxt = (in_rx_byte == TERM_BYTE) ? ff_run_r + 2'd1 : 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_seen_r <= 3'd0;
      ff_run_r     <= 2'd0;
      for (int i = 0; i < HEAD_LEN; i++) head_r[i] <= 8'd0;
    end else if (byte_beat) begin
      bytes_seen_r <= bytes_seen_nxt;
      ff_run_r     <= ff_run_nxt;
      for (int i = 0; i < HEAD_LEN; i++) head_r[i] <= frame_end ? 8'd0 : head_nxt[i];
    end
  end

  // classify the beat into a job for the back side
  assign code = head_nxt[0];

  always_comb begin
    job_valid      = 1'b0;
    q_job.op       = OP_REG;
    q_job.want_rel = 1'b0;
    q_job.data     = {15'd0, in_on_release_flag, in_handler_page, in_handler_id};
    if (in_req_type == REQ_REGISTER) begin
      job_valid = 1'b1;
    end else if (frame_end) begin
      if (code <= ERR_LIMIT) begin
        job_valid  = 1'b1;
        q_job.op   = OP_ERR;
        q_job.data = {24'd0, code};
      end else if (code == touch_code_r) begin
        // only a press or release marker can match a handler
        q_job.op       = OP_TOUCH;
        q_job.data     = {16'd0, head_nxt[2], head_nxt[1]};
        q_job.want_rel = (head_nxt[3] == RELEASE_BYTE);
        job_valid      = (head_nxt[3] == RELEASE_BYTE) || (head_nxt[3] == PRESS_BYTE);
      end else if (code == page_code_r) begin
        job_valid  = 1'b1;
        q_job.op   = OP_PAGE;
        q_job.data = {24'd0, head_nxt[1]};
      end else if (code == num_code_r) begin
        job_valid  = 1'b1;
        q_job.op   = OP_NUM;
        q_job.data = {head_nxt[4], head_nxt[3], head_nxt[2], head_nxt[1]};
      end
    end
  end

  assign q_push = accept && job_valid;

endmodule

// ===== design/drfd_queue.sv =====
// two-entry job queue between front and back sides
// depends on drfd_pkg
`timescale 1ns / 1ps

module drfd_queue import drfd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_push,
  input  job_t wr_job,
  input  logic rd_pop,
  output logic wr_full,
  output logic rd_empty,
  output job_t rd_job
);

  localparam int unsigned DEPTH = 2;

  job_t       mem_r [DEPTH];
  logic       wptr_r, rptr_r;
  logic [1:0] cnt_r;
  logic       do_push, do_pop;

  assign do_push = wr_push && (cnt_r != 2'(DEPTH));
  assign do_pop  = rd_pop && (cnt_r != 2'd0);

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wptr_r] <= wr_job;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (do_push) wptr_r <= ~wptr_r;
      if (do_pop)  rptr_r <= ~rptr_r;
      cnt_r <= cnt_r + 2'(do_push) - 2'(do_pop);
    end
  end

  assign wr_full  = (cnt_r == 2'(DEPTH));
  assign rd_empty = (cnt_r == 2'd0);
  assign rd_job   = mem_r[rptr_r];

endmodule

// ===== design/drfd_back.sv =====
// back side: handler table, slot walk for touch frames and result register
// depends on drfd_pkg; takes jobs from drfd_queue
`timescale 1ns / 1ps

module drfd_back import drfd_pkg::*; #(
  parameter int unsigned HANDLER_SLOTS = HANDLER_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_empty,
  input  job_t        q_job,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_result_kind,
  output logic [31:0] out_result_value,
  output logic [3:0]  out_handler_slot,
  output logic        out_last_result
);

  localparam int unsigned IDX_W = (HANDLER_SLOTS > 1) ? $clog2(HANDLER_SLOTS) : 1;
  localparam int unsigned CNT_W = $clog2(HANDLER_SLOTS + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

  state_t      state_r, state_nxt;
  logic [16:0] table_mem [HANDLER_SLOTS];
  logic [16:0] rdata_r;
  logic        mem_we;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [3:0]  hits_r, hits_nxt;
  logic        pend_v_r, pend_v_nxt;
  logic [3:0]  pend_slot_r, pend_slot_nxt;
  logic [7:0]  t_page_r, t_page_nxt, t_id_r, t_id_nxt;
  logic        t_rel_r, t_rel_nxt;
  logic        ov_r, ov_nxt;
  logic [1:0]  ok_r, ok_nxt;
  logic [31:0] oval_r, oval_nxt;
  logic [3:0]  oslot_r, oslot_nxt;
  logic        olast_r, olast_nxt;
  logic        out_free, hit, walk_done;

  // handler table: one write port, registered read at the next walk index
  always_ff @(posedge clk) begin
    if (mem_we) table_mem[count_r[IDX_W-1:0]] <= q_job.data[16:0];
    rdata_r <= table_mem[idx_nxt];
  end

  assign out_free  = !ov_r || !out_stall;
  assign hit       = (rdata_r[15:8] == t_page_r) && (rdata_r[7:0] == t_id_r) &&
                     (rdata_r[16] == t_rel_r);
  assign walk_done = (hit && (hits_r == 4'(MAX_MATCHES - 1))) ||
                     (CNT_W'(idx_r) + CNT_W'(1) == count_r);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    q_pop         = 1'b0;
    mem_we        = 1'b0;
    idx_nxt       = idx_r;
    count_nxt     = count_r;
    hits_nxt      = hits_r;
    pend_v_nxt    = pend_v_r;
    pend_slot_nxt = pend_slot_r;
    t_page_nxt    = t_page_r;
    t_id_nxt      = t_id_r;
    t_rel_nxt     = t_rel_r;
    ov_nxt        = ov_r && out_stall;
    ok_nxt        = ok_r;
    oval_nxt      = oval_r;
    oslot_nxt     = oslot_r;
    olast_nxt     = olast_r;
    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          case (q_job.op)
            OP_REG: begin
              q_pop = 1'b1;
              if (count_r < CNT_W'(HANDLER_SLOTS)) begin
                mem_we    = 1'b1;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            OP_TOUCH: begin
              q_pop      = 1'b1;
              idx_nxt    = '0;
              hits_nxt   = 4'd0;
              pend_v_nxt = 1'b0;
              t_page_nxt = q_job.data[7:0];
              t_id_nxt   = q_job.data[15:8];
              t_rel_nxt  = q_job.want_rel;
              if (count_r != '0) state_nxt = ST_WALK;
            end
            OP_ERR, OP_PAGE, OP_NUM: begin
              if (out_free) begin
                q_pop     = 1'b1;
                ov_nxt    = 1'b1;
                ok_nxt    = (q_job.op == OP_ERR)  ? KIND_ERROR :
                            (q_job.op == OP_PAGE) ? KIND_PAGE  : KIND_NUM;
                oval_nxt  = q_job.data;
                oslot_nxt = 4'd0;
                olast_nxt = 1'b1;
              end
            end
            default: q_pop = 1'b1;
          endcase
        end
      end
      ST_WALK: begin
        // a new hit pushes the held one out, which needs the result register
        if (!(hit && pend_v_r && !out_free)) begin
          if (hit && pend_v_r) begin
            ov_nxt    = 1'b1;
            ok_nxt    = KIND_TOUCH;
            oval_nxt  = 32'd0;
            oslot_nxt = pend_slot_r;
            olast_nxt = 1'b0;
          end
          if (hit) begin
            pend_v_nxt    = 1'b1;
            pend_slot_nxt = 4'(idx_r);
            hits_nxt      = hits_r + 4'd1;
          end
          if (walk_done) state_nxt = ST_FIN;
          else           idx_nxt   = idx_r + IDX_W'(1);
        end
      end
      ST_FIN: begin
        // held hit is the last result of the frame
        if (!pend_v_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          ov_nxt     = 1'b1;
          ok_nxt     = KIND_TOUCH;
          oval_nxt   = 32'd0;
          oslot_nxt  = pend_slot_r;
          olast_nxt  = 1'b1;
          pend_v_nxt = 1'b0;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      count_r  <= '0;
      idx_r    <= '0;
      hits_r   <= 4'd0;
      pend_v_r <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      idx_r    <= idx_nxt;
      hits_r   <= hits_nxt;
      pend_v_r <= pend_v_nxt;
      ov_r     <= ov_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pend_slot_r <= pend_slot_nxt;
    t_page_r    <= t_page_nxt;
    t_id_r      <= t_id_nxt;
    t_rel_r     <= t_rel_nxt;
    ok_r        <= ok_nxt;
    oval_r      <= oval_nxt;
    oslot_r     <= oslot_nxt;
    olast_r     <= olast_nxt;
  end

  assign out_valid        = ov_r;
  assign out_result_kind  = ok_r;
  assign out_result_value = oval_r;
  assign out_handler_slot = oslot_r;
  assign out_last_result  = olast_r;

endmodule
